// ----- hw/rtl/epd_pkg.sv -----
`default_nettype none

package epd_pkg;

   localparam logic [7:0] BYTE_START     = 8'hAA;
   localparam logic [7:0] BYTE_ESCAPE    = 8'hBB;
   localparam logic [7:0] BYTE_END       = 8'hCC;
   localparam logic [7:0] ESC_FOR_START  = 8'h55;
   localparam logic [7:0] ESC_FOR_ESCAPE = 8'h44;
   localparam logic [7:0] ESC_FOR_END    = 8'h33;
   localparam logic [7:0] TALLY_MAX      = 8'hFF;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_BAD     = 2'd2,
      KIND_ABORT   = 2'd3
   } epd_kind_type;

   typedef struct packed {
      epd_kind_type kind;
      logic [7:0]   data_byte;
      logic [7:0]   error_count;
   } epd_result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/epd_step.sv -----
`default_nettype none

module epd_step
   import epd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           fire,
   input  wire logic [7:0]     rx_byte,
   output logic                res_valid,
   output epd_result_type      res
);

   logic       in_packet_ff, in_packet_in;
   logic       in_escape_ff, in_escape_in;
   logic       held_valid_ff, held_valid_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] error_tally_ff, error_tally_in;

   logic [7:0] tally_bump;
   logic       do_push;
   logic [7:0] push_byte;
   logic       good;

   assign tally_bump = (error_tally_ff == TALLY_MAX) ? TALLY_MAX : error_tally_ff + 8'd1;
   assign good       = held_valid_ff && (running_sum_ff == held_byte_ff);

   always_comb begin
      in_packet_in   = in_packet_ff;
      in_escape_in   = in_escape_ff;
      held_valid_in  = held_valid_ff;
      held_byte_in   = held_byte_ff;
      running_sum_in = running_sum_ff;
      error_tally_in = error_tally_ff;
      res_valid      = 1'b0;
      res.kind       = KIND_PAYLOAD;
      res.data_byte  = 8'd0;
      do_push        = 1'b0;
      push_byte      = rx_byte;

      priority if (rx_byte == BYTE_START) begin
         if (in_packet_ff) begin
            error_tally_in = tally_bump;
            res_valid      = 1'b1;
            res.kind       = KIND_ABORT;
         end
         in_packet_in   = 1'b1;
         in_escape_in   = 1'b0;
         held_valid_in  = 1'b0;
         held_byte_in   = 8'd0;
         running_sum_in = 8'd0;
      end else if (!in_packet_ff) begin
         // idle line: drop
      end else if (rx_byte == BYTE_END) begin
         error_tally_in = good ? 8'd0 : tally_bump;
         res_valid      = 1'b1;
         res.kind       = good ? KIND_GOOD : KIND_BAD;
         in_packet_in   = 1'b0;
         in_escape_in   = 1'b0;
         held_valid_in  = 1'b0;
         held_byte_in   = 8'd0;
         running_sum_in = 8'd0;
      end else if (in_escape_ff) begin
         in_escape_in = 1'b0;
         unique case (rx_byte)
            ESC_FOR_START: begin
               do_push   = 1'b1;
               push_byte = BYTE_START;
            end
            ESC_FOR_ESCAPE: begin
               do_push   = 1'b1;
               push_byte = BYTE_ESCAPE;
            end
            ESC_FOR_END: begin
               do_push   = 1'b1;
               push_byte = BYTE_END;
            end
            default: begin
               error_tally_in = tally_bump;
            end
         endcase
      end else if (rx_byte == BYTE_ESCAPE) begin
         in_escape_in = 1'b1;
      end else begin
         do_push = 1'b1;
      end

      // release the held byte as payload, hold the new one
      if (do_push) begin
         if (held_valid_ff) begin
            running_sum_in = running_sum_ff + held_byte_ff;
            res_valid      = 1'b1;
            res.kind       = KIND_PAYLOAD;
            res.data_byte  = held_byte_ff;
         end
         held_byte_in  = push_byte;
         held_valid_in = 1'b1;
      end

      res.error_count = error_tally_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff   <= 1'b0;
         in_escape_ff   <= 1'b0;
         held_valid_ff  <= 1'b0;
         held_byte_ff   <= 8'd0;
         running_sum_ff <= 8'd0;
         error_tally_ff <= 8'd0;
      end else if (fire) begin
         in_packet_ff   <= in_packet_in;
         in_escape_ff   <= in_escape_in;
         held_valid_ff  <= held_valid_in;
         held_byte_ff   <= held_byte_in;
         running_sum_ff <= running_sum_in;
         error_tally_ff <= error_tally_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/escaped_packet_deframer_top.sv -----
// Channel   Direction  Ports             Contents
// req       in         req_tdata[7:0]    rx_byte
// rsp       out        rsp_tdata[15:0]   data_byte, error_count
//                      rsp_tuser[1:0]    result_kind
//
// One raw byte per cycle while rsp is not stalled: a byte lands in the input
// register, is decoded against the framing state in a single pass, and its
// result (if any) is written to the output register when the decode advances.
// Reset (synchronous, active high) clears the framing state and error count.
// A stalled rsp side holds its result; req keeps accepting while the
// input register can advance into a free or draining output register.
`default_nettype none

module escaped_packet_deframer_top
   import epd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] data_byte, [15:8] error_count
   output logic [1:0]       rsp_tuser    // [1:0] result_kind
);

   // Input register: holds one received byte awaiting decode.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // Output register: one finished result awaiting transfer.
   logic           out_valid_ff, out_valid_in;
   epd_result_type out_res_ff;

   logic           advance;
   logic           step_valid;
   epd_result_type step_res;

   // Advance the decode when a byte is waiting and the output slot is free
   // or being emptied by this cycle's transfer.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   epd_step u_step (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .rx_byte   (in_byte_ff),
      .res_valid (step_valid),
      .res       (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = step_valid;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload register loads only with a real result.
   always_ff @(posedge clock) begin
      if (advance && step_valid) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_res_ff.error_count, out_res_ff.data_byte};
   assign rsp_tuser  = out_res_ff.kind;

endmodule

`default_nettype wire
